// File: sv/gna_pkg.sv
// gna_pkg: shared constants, trig series tables and latency helpers
// for the gaussian noise adder. No dependencies.
package gna_pkg;

	localparam int UNIFORM_BITS = 16;
	localparam int COORD_W      = 32;
	localparam int SIGMA_W      = 24;
	localparam logic [SIGMA_W-1:0] SIGMA_RESET = 24'd65536;

	localparam int LOG_FRAC = 28;
	localparam logic [30:0] LN2X2_Q30   = 31'd1488522236;
	localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;

	localparam int X_W        = 31;
	localparam int X2_W       = 32;
	localparam int TERM_W     = 32;
	localparam int TPROD_W    = 33;
	localparam int RECIP_W    = 33;
	localparam int DIV_W      = 8;
	localparam int CMAG_W     = 31;
	localparam int TSUM_W     = 35;
	localparam int TRIG_STEPS = 7;
	localparam int TRIG_LAT   = 2 + 3 * TRIG_STEPS + 1;

	localparam logic [DIV_W-1:0] COS_DIV [TRIG_STEPS] =
		'{8'd2, 8'd12, 8'd30, 8'd56, 8'd90, 8'd132, 8'd182};
	localparam logic [DIV_W-1:0] SIN_DIV [TRIG_STEPS] =
		'{8'd6, 8'd20, 8'd42, 8'd72, 8'd110, 8'd156, 8'd210};

	// floor(2^33 / divisor)
	localparam logic [RECIP_W-1:0] COS_RECIP [TRIG_STEPS] =
		'{33'd4294967296, 33'd715827882, 33'd286331153, 33'd153391689,
		  33'd95443717, 33'd65075262, 33'd47197442};
	localparam logic [RECIP_W-1:0] SIN_RECIP [TRIG_STEPS] =
		'{33'd1431655765, 33'd429496729, 33'd204522252, 33'd119304647,
		  33'd78090314, 33'd55063683, 33'd40904450};

	function automatic int k_w(input int ub);
		return $clog2(ub + 1);
	endfunction

	function automatic int t_w(input int ub);
		return k_w(ub) + LOG_FRAC;
	endfunction

	function automatic int sq_steps(input int ub);
		return (t_w(ub) + 30) >> 1;
	endfunction

	function automatic int rad_lat(input int ub);
		return 1 + LOG_FRAC + 2 + sq_steps(ub);
	endfunction

	function automatic int lane_lat(input int ub);
		return rad_lat(ub) + 4;
	endfunction

endpackage

// File: sv/gna_if.sv
// gna_if: valid/ready channel interfaces for input points and noisy results
// depends on gna_pkg
interface gna_pt_if #(parameter int UB = gna_pkg::UNIFORM_BITS);
	logic valid;
	logic ready;
	logic signed [31:0] coord_x;
	logic signed [31:0] coord_y;
	logic signed [31:0] coord_z;
	logic [UB-1:0] radius_code_x;
	logic [UB-1:0] angle_code_x;
	logic [UB-1:0] radius_code_y;
	logic [UB-1:0] angle_code_y;
	logic [UB-1:0] radius_code_z;
	logic [UB-1:0] angle_code_z;

	modport source(output valid, coord_x, coord_y, coord_z, radius_code_x, angle_code_x,
		radius_code_y, angle_code_y, radius_code_z, angle_code_z, input ready);
	modport sink(input valid, coord_x, coord_y, coord_z, radius_code_x, angle_code_x,
		radius_code_y, angle_code_y, radius_code_z, angle_code_z, output ready);
endinterface

interface gna_res_if;
	logic valid;
	logic ready;
	logic signed [31:0] noisy_x;
	logic signed [31:0] noisy_y;
	logic signed [31:0] noisy_z;

	modport source(output valid, noisy_x, noisy_y, noisy_z, input ready);
	modport sink(input valid, noisy_x, noisy_y, noisy_z, output ready);
endinterface

// File: sv/gna_radius.sv
// gna_radius: pipelined sqrt(-2 ln u) for one lane, log2 by repeated squaring
// then a digit-per-stage integer square root; depends on gna_pkg
module gna_radius #(
	parameter int UB = gna_pkg::UNIFORM_BITS
) (
	input  logic clk,
	input  logic en,
	input  logic [UB-1:0] radius_code,
	output logic [gna_pkg::sq_steps(UB)-1:0] rad
);
	localparam int M_W      = UB + 1;
	localparam int K_W      = gna_pkg::k_w(UB);
	localparam int T_W      = gna_pkg::t_w(UB);
	localparam int LF       = gna_pkg::LOG_FRAC;
	localparam int SQ_STEPS = gna_pkg::sq_steps(UB);
	localparam int SQ_IN_W  = 2 * SQ_STEPS;
	localparam int RAD_W    = SQ_STEPS;
	localparam int RW       = SQ_STEPS + 3;
	localparam int TP_W     = T_W + 31;

	logic [M_W-1:0] m;
	logic [K_W-1:0] k_c;
	logic [M_W+30:0] mext;
	logic [31:0] xnorm;

	assign m = M_W'(radius_code) + M_W'(1);
	assign mext = {m, 31'b0};
	assign xnorm = 32'(mext >> k_c);

	always_comb begin
		k_c = '0;
		for (int i = 0; i < M_W; i++) begin
			if (m[i]) begin
				k_c = K_W'(i);
			end
		end
	end

	logic [K_W-1:0] k_s1;
	logic [31:0] x_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			k_s1 <= k_c;
			x_s1 <= xnorm;
		end
	end

	// log2 fraction, one bit per stage
	logic [31:0] lx_s [LF];
	logic [LF-1:0] lfrac_s [LF];
	logic [K_W-1:0] lk_s [LF];

	for (genvar i = 0; i < LF; i++) begin : g_log
		logic [31:0] cur_x;
		logic [LF-1:0] cur_frac;
		logic [K_W-1:0] cur_k;
		logic [63:0] sq;
		logic [32:0] s;

		if (i == 0) begin : g_first
			assign cur_x = x_s1;
			assign cur_frac = '0;
			assign cur_k = k_s1;
		end else begin : g_next
			assign cur_x = lx_s[i-1];
			assign cur_frac = lfrac_s[i-1];
			assign cur_k = lk_s[i-1];
		end

		assign sq = 64'(cur_x) * 64'(cur_x);
		assign s = sq[63:31];

		always_ff @(posedge clk) begin
			if (en) begin
				lx_s[i] <= s[32] ? s[32:1] : s[31:0];
				lfrac_s[i] <= cur_frac | (LF'(s[32]) << (LF - 1 - i));
				lk_s[i] <= cur_k;
			end
		end
	end

	logic [T_W-1:0] lval;
	logic [T_W-1:0] t;
	logic [TP_W-1:0] tp_s;
	logic [TP_W-1:0] rsum;
	logic [T_W+2:0] r2;
	logic [SQ_IN_W-1:0] v_s;

	assign lval = {lk_s[LF-1], lfrac_s[LF-1]};
	assign t = (T_W'(UB) << LF) - lval;
	assign rsum = tp_s + (TP_W'(1) << 27);
	assign r2 = rsum[TP_W-1:28];

	always_ff @(posedge clk) begin
		if (en) begin
			tp_s <= TP_W'(t) * TP_W'(gna_pkg::LN2X2_Q30);
			v_s <= SQ_IN_W'({r2, 26'b0});
		end
	end

	// integer square root, one result bit per stage
	logic [SQ_IN_W-1:0] sv_s [SQ_STEPS];
	logic [RW-1:0] srem_s [SQ_STEPS];
	logic [RAD_W-1:0] sroot_s [SQ_STEPS];

	for (genvar j = 0; j < SQ_STEPS; j++) begin : g_sqrt
		logic [SQ_IN_W-1:0] cur_v;
		logic [RW-1:0] cur_rem;
		logic [RAD_W-1:0] cur_root;
		logic [RW-1:0] remw;
		logic [RW-1:0] trial;
		logic ge;

		if (j == 0) begin : g_first
			assign cur_v = v_s;
			assign cur_rem = '0;
			assign cur_root = '0;
		end else begin : g_next
			assign cur_v = sv_s[j-1];
			assign cur_rem = srem_s[j-1];
			assign cur_root = sroot_s[j-1];
		end

		assign remw = {cur_rem[RW-3:0], cur_v[SQ_IN_W-1 -: 2]};
		assign trial = RW'({cur_root, 2'b01});
		assign ge = remw >= trial;

		always_ff @(posedge clk) begin
			if (en) begin
				sv_s[j] <= cur_v << 2;
				srem_s[j] <= ge ? remw - trial : remw;
				sroot_s[j] <= {cur_root[RAD_W-2:0], ge};
			end
		end
	end

	assign rad = sroot_s[SQ_STEPS-1];

endmodule

// File: sv/gna_trig.sv
// gna_trig: pipelined quadrant cos/sin of 2*pi*b by a Taylor series
// each term: multiply, reciprocal divide, correct and accumulate; depends on gna_pkg
module gna_trig #(
	parameter int UB = gna_pkg::UNIFORM_BITS
) (
	input  logic clk,
	input  logic en,
	input  logic [UB-1:0] angle_code,
	output logic [gna_pkg::CMAG_W-1:0] cmag,
	output logic neg
);
	localparam int X_W     = gna_pkg::X_W;
	localparam int X2_W    = gna_pkg::X2_W;
	localparam int TERM_W  = gna_pkg::TERM_W;
	localparam int TPROD_W = gna_pkg::TPROD_W;
	localparam int RECIP_W = gna_pkg::RECIP_W;
	localparam int DIV_W   = gna_pkg::DIV_W;
	localparam int CMAG_W  = gna_pkg::CMAG_W;
	localparam int TSUM_W  = gna_pkg::TSUM_W;
	localparam int STEPS   = gna_pkg::TRIG_STEPS;

	logic [31:0] p32;
	logic [60:0] xprod;

	assign p32 = 32'(angle_code) << (32 - UB);
	assign xprod = 61'(p32[29:0]) * 61'(gna_pkg::HALF_PI_Q30);

	logic [X_W-1:0] x_s1;
	logic [1:0] quad_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1 <= xprod[60:30];
			quad_s1 <= p32[31:30];
		end
	end

	logic [61:0] x2prod;
	logic [TERM_W-1:0] term0;
	assign x2prod = 62'(x_s1) * 62'(x_s1);
	assign term0 = quad_s1[0] ? TERM_W'(x_s1) : TERM_W'(32'h4000_0000);

	logic [X2_W-1:0] x2_s2;
	logic [TERM_W-1:0] term_s2;
	logic signed [TSUM_W-1:0] sum_s2;
	logic [1:0] quad_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			x2_s2 <= x2prod[61:30];
			term_s2 <= term0;
			sum_s2 <= signed'(TSUM_W'(term0));
			quad_s2 <= quad_s1;
		end
	end

	logic [TPROD_W-1:0] prod_sa [STEPS];
	logic [X2_W-1:0] x2_sa [STEPS];
	logic signed [TSUM_W-1:0] sum_sa [STEPS];
	logic [1:0] quad_sa [STEPS];

	logic [TPROD_W-1:0] q0_sb [STEPS];
	logic [TPROD_W-1:0] prod_sb [STEPS];
	logic [X2_W-1:0] x2_sb [STEPS];
	logic signed [TSUM_W-1:0] sum_sb [STEPS];
	logic [1:0] quad_sb [STEPS];

	logic [TERM_W-1:0] term_sc [STEPS];
	logic [X2_W-1:0] x2_sc [STEPS];
	logic signed [TSUM_W-1:0] sum_sc [STEPS];
	logic [1:0] quad_sc [STEPS];

	for (genvar k = 0; k < STEPS; k++) begin : g_term
		logic [TERM_W-1:0] cur_term;
		logic [X2_W-1:0] cur_x2;
		logic signed [TSUM_W-1:0] cur_sum;
		logic [1:0] cur_quad;
		logic [63:0] mul_a;
		logic [RECIP_W-1:0] recip;
		logic [65:0] mul_b;
		logic [DIV_W-1:0] dv;
		logic [40:0] qd;
		logic [TPROD_W-1:0] rem;
		logic [TPROD_W-1:0] q;
		logic signed [TSUM_W-1:0] qext;

		if (k == 0) begin : g_first
			assign cur_term = term_s2;
			assign cur_x2 = x2_s2;
			assign cur_sum = sum_s2;
			assign cur_quad = quad_s2;
		end else begin : g_next
			assign cur_term = term_sc[k-1];
			assign cur_x2 = x2_sc[k-1];
			assign cur_sum = sum_sc[k-1];
			assign cur_quad = quad_sc[k-1];
		end

		assign mul_a = 64'(cur_term) * 64'(cur_x2);
		assign recip = quad_sa[k][0] ? gna_pkg::SIN_RECIP[k] : gna_pkg::COS_RECIP[k];
		assign mul_b = 66'(prod_sa[k]) * 66'(recip);
		assign dv = quad_sb[k][0] ? gna_pkg::SIN_DIV[k] : gna_pkg::COS_DIV[k];
		assign qd = 41'(q0_sb[k]) * 41'(dv);
		assign rem = prod_sb[k] - qd[TPROD_W-1:0];
		assign q = (rem >= TPROD_W'(dv)) ? q0_sb[k] + TPROD_W'(1) : q0_sb[k];
		assign qext = signed'(TSUM_W'(q[TERM_W-1:0]));

		always_ff @(posedge clk) begin
			if (en) begin
				prod_sa[k] <= mul_a[62:30];
				x2_sa[k] <= cur_x2;
				sum_sa[k] <= cur_sum;
				quad_sa[k] <= cur_quad;

				q0_sb[k] <= mul_b[65:33];
				prod_sb[k] <= prod_sa[k];
				x2_sb[k] <= x2_sa[k];
				sum_sb[k] <= sum_sa[k];
				quad_sb[k] <= quad_sa[k];

				term_sc[k] <= q[TERM_W-1:0];
				x2_sc[k] <= x2_sb[k];
				sum_sc[k] <= (k % 2 == 0) ? sum_sb[k] - qext : sum_sb[k] + qext;
				quad_sc[k] <= quad_sb[k];
			end
		end
	end

	logic signed [TSUM_W-1:0] last_sum;
	logic [1:0] last_quad;
	logic [CMAG_W-1:0] clamped;

	assign last_sum = sum_sc[STEPS-1];
	assign last_quad = quad_sc[STEPS-1];

	always_comb begin
		if (last_sum < 0) begin
			clamped = '0;
		end else if (last_sum > signed'(TSUM_W'(32'h4000_0000))) begin
			clamped = CMAG_W'(32'h4000_0000);
		end else begin
			clamped = last_sum[CMAG_W-1:0];
		end
	end

	logic [CMAG_W-1:0] cmag_so;
	logic neg_so;

	always_ff @(posedge clk) begin
		if (en) begin
			cmag_so <= clamped;
			neg_so <= last_quad[1] ^ last_quad[0];
		end
	end

	assign cmag = cmag_so;
	assign neg = neg_so;

endmodule

// File: sv/gna_lane.sv
// gna_lane: one coordinate lane, radius and trig units, scaling by sigma,
// rounding and saturating add; depends on gna_pkg, gna_radius, gna_trig
module gna_lane #(
	parameter int UB = gna_pkg::UNIFORM_BITS
) (
	input  logic clk,
	input  logic en,
	input  logic signed [31:0] coord,
	input  logic [UB-1:0] radius_code,
	input  logic [UB-1:0] angle_code,
	input  logic [gna_pkg::SIGMA_W-1:0] sigma,
	output logic signed [31:0] noisy
);
	localparam int RAD_W   = gna_pkg::sq_steps(UB);
	localparam int RAD_LAT = gna_pkg::rad_lat(UB);
	localparam int DLY     = RAD_LAT - gna_pkg::TRIG_LAT;
	localparam int CMAG_W  = gna_pkg::CMAG_W;
	localparam int SIGMA_W = gna_pkg::SIGMA_W;
	localparam int P1_W    = RAD_W + 31;
	localparam int G_W     = RAD_W - 3;
	localparam int P2_W    = G_W + SIGMA_W;

	logic [RAD_W-1:0] rad;
	logic [CMAG_W-1:0] cmag;
	logic neg;

	gna_radius #(.UB(UB)) u_radius (
		.clk(clk),
		.en(en),
		.radius_code(radius_code),
		.rad(rad)
	);

	gna_trig #(.UB(UB)) u_trig (
		.clk(clk),
		.en(en),
		.angle_code(angle_code),
		.cmag(cmag),
		.neg(neg)
	);

	logic [CMAG_W-1:0] cmag_d_s [DLY];
	logic neg_d_s [DLY];

	for (genvar i = 0; i < DLY; i++) begin : g_tdly
		logic [CMAG_W-1:0] cur_c;
		logic cur_n;
		if (i == 0) begin : g_first
			assign cur_c = cmag;
			assign cur_n = neg;
		end else begin : g_next
			assign cur_c = cmag_d_s[i-1];
			assign cur_n = neg_d_s[i-1];
		end
		always_ff @(posedge clk) begin
			if (en) begin
				cmag_d_s[i] <= cur_c;
				neg_d_s[i] <= cur_n;
			end
		end
	end

	logic signed [31:0] coord_d_s [RAD_LAT];

	for (genvar i = 0; i < RAD_LAT; i++) begin : g_cdly
		logic signed [31:0] cur;
		if (i == 0) begin : g_first
			assign cur = coord;
		end else begin : g_next
			assign cur = coord_d_s[i-1];
		end
		always_ff @(posedge clk) begin
			if (en) begin
				coord_d_s[i] <= cur;
			end
		end
	end

	logic [P1_W-1:0] p1_s1;
	logic neg_s1;
	logic signed [31:0] coord_s1;
	logic [G_W-1:0] gmag_s2;
	logic neg_s2;
	logic signed [31:0] coord_s2;
	logic [P2_W-1:0] p2_s3;
	logic neg_s3;
	logic signed [31:0] coord_s3;
	logic signed [31:0] noisy_s4;

	logic [P1_W-1:0] gsum;
	logic [P2_W-1:0] nsum;
	logic [G_W-1:0] nmag;
	logic signed [33:0] cext;
	logic signed [33:0] next;
	logic signed [33:0] total;
	logic signed [31:0] sat;

	assign gsum = p1_s1 + (P1_W'(1) << 33);
	assign nsum = p2_s3 + (P2_W'(1) << 23);
	assign nmag = nsum[P2_W-1:24];
	assign cext = 34'(coord_s3);
	assign next = signed'(34'(nmag));
	assign total = neg_s3 ? cext - next : cext + next;

	always_comb begin
		if (total > signed'(34'sh0_7FFF_FFFF)) begin
			sat = 32'sh7FFF_FFFF;
		end else if (total < -signed'(34'sh0_8000_0000)) begin
			sat = 32'sh8000_0000;
		end else begin
			sat = total[31:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p1_s1 <= P1_W'(rad) * P1_W'(cmag_d_s[DLY-1]);
			neg_s1 <= neg_d_s[DLY-1];
			coord_s1 <= coord_d_s[RAD_LAT-1];

			gmag_s2 <= gsum[P1_W-1:34];
			neg_s2 <= neg_s1;
			coord_s2 <= coord_s1;

			p2_s3 <= P2_W'(gmag_s2) * P2_W'(sigma);
			neg_s3 <= neg_s2;
			coord_s3 <= coord_s2;

			noisy_s4 <= sat;
		end
	end

	assign noisy = noisy_s4;

endmodule

// File: sv/gaussian_noise_adder_core.sv
// gaussian_noise_adder_core: three coordinate lanes, valid tracking and the
// output register with skid; depends on gna_pkg, gna_if, gna_lane
//
// Takes one point per clock while ready is high and returns it with
// Box-Muller noise scaled by noise_sigma added to each coordinate. Three
// identical lanes run in lockstep; each is a fixed pipeline whose depth is
// set by the 28-stage log2 squaring chain and the one-bit-per-stage square
// root, lane_lat(UNIFORM_BITS) stages (66 at 16 bits), followed by one output
// register. A skid register behind the output register lets the pipeline
// keep taking words while a result waits; ready drops only once the skid
// holds a word, and the whole pipeline then holds until the output drains.
// noise_sigma resets to 1.0.
module gaussian_noise_adder_core #(
	parameter int UNIFORM_BITS = gna_pkg::UNIFORM_BITS
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_wr_en,
	input  logic [gna_pkg::SIGMA_W-1:0] cfg_wr_data,
	gna_pt_if.sink in_pt,
	gna_res_if.source out_pt
);
	localparam int LAT = gna_pkg::lane_lat(UNIFORM_BITS);

	logic [gna_pkg::SIGMA_W-1:0] sigma_q;
	logic [LAT-1:0] vld_q;
	logic en;
	logic accept;
	logic push;
	logic take;
	logic out_vld_q;
	logic skid_vld_q;
	logic signed [31:0] lane_x, lane_y, lane_z;
	logic signed [31:0] out_x_q, out_y_q, out_z_q;
	logic signed [31:0] skid_x_q, skid_y_q, skid_z_q;

	assign en = !skid_vld_q;
	assign accept = in_pt.valid && en;
	assign in_pt.ready = en;
	assign push = en && vld_q[LAT-1];
	assign take = out_vld_q && out_pt.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sigma_q <= gna_pkg::SIGMA_RESET;
		end else if (cfg_wr_en) begin
			sigma_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], accept};
		end
	end

	gna_lane #(.UB(UNIFORM_BITS)) u_lane_x (
		.clk(clk), .en(en), .coord(in_pt.coord_x),
		.radius_code(in_pt.radius_code_x), .angle_code(in_pt.angle_code_x),
		.sigma(sigma_q), .noisy(lane_x)
	);

	gna_lane #(.UB(UNIFORM_BITS)) u_lane_y (
		.clk(clk), .en(en), .coord(in_pt.coord_y),
		.radius_code(in_pt.radius_code_y), .angle_code(in_pt.angle_code_y),
		.sigma(sigma_q), .noisy(lane_y)
	);

	gna_lane #(.UB(UNIFORM_BITS)) u_lane_z (
		.clk(clk), .en(en), .coord(in_pt.coord_z),
		.radius_code(in_pt.radius_code_z), .angle_code(in_pt.angle_code_z),
		.sigma(sigma_q), .noisy(lane_z)
	);

	// output word and skid control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (take || !out_vld_q) begin
			if (skid_vld_q) begin
				out_vld_q <= 1'b1;
				skid_vld_q <= 1'b0;
			end else begin
				out_vld_q <= push;
			end
		end else if (push) begin
			skid_vld_q <= 1'b1;
		end
	end

	// merged lane results
	always_ff @(posedge clk) begin
		if (take || !out_vld_q) begin
			if (skid_vld_q) begin
				out_x_q <= skid_x_q;
				out_y_q <= skid_y_q;
				out_z_q <= skid_z_q;
			end else if (push) begin
				out_x_q <= lane_x;
				out_y_q <= lane_y;
				out_z_q <= lane_z;
			end
		end else if (push) begin
			skid_x_q <= lane_x;
			skid_y_q <= lane_y;
			skid_z_q <= lane_z;
		end
	end

	assign out_pt.valid = out_vld_q;
	assign out_pt.noisy_x = out_x_q;
	assign out_pt.noisy_y = out_y_q;
	assign out_pt.noisy_z = out_z_q;

	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q |-> out_vld_q)
		else $error("skid holds a word while output is empty");

	a_push_lands: assert property (@(posedge clk) disable iff (!arst_n)
		push |=> out_vld_q)
		else $error("pipeline word dropped at output");

	a_skid_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_vld_q) |-> $past(out_vld_q && !out_pt.ready))
		else $error("skid filled without an output stall");

endmodule

// File: sim/tb_gaussian_noise_adder_core.sv
// tb_gaussian_noise_adder_core: random and directed test of the Box-Muller noise adder
// with a bit-exact fixed-point predictor and an in-order result scoreboard
// depends on gna_pkg, gna_if and gaussian_noise_adder_core
module tb_gaussian_noise_adder_core;

	typedef struct {
		logic signed [31:0] coord [3];
		logic [gna_pkg::UNIFORM_BITS-1:0] rcode [3];
		logic [gna_pkg::UNIFORM_BITS-1:0] acode [3];
	} point_t;

	typedef struct {
		logic signed [31:0] noisy [3];
	} noisy_pt_t;

	localparam int IDLE_LIMIT = 5000;
	localparam int DRAIN_CYCLES = 100;
	localparam logic [63:0] ONE_Q30 = 64'd1 << 30;

	class noise_scoreboard;
		logic [gna_pkg::SIGMA_W-1:0] sigma;
		noisy_pt_t pending [$];

		function new();
			sigma = gna_pkg::SIGMA_RESET;
		endfunction

		function longint rshift_round(longint v, int n);
			longint unsigned mag;
			mag = (v < 0) ? -v : v;
			mag = (mag + (64'd1 << (n - 1))) >> n;
			return (v < 0) ? -longint'(mag) : longint'(mag);
		endfunction

		function longint unsigned int_sqrt(longint unsigned v);
			longint unsigned r, b;
			r = 0;
			b = 64'd1 << 62;
			while (b > v) b = b >> 2;
			while (b != 0) begin
				if (v >= r + b) begin
					v = v - (r + b);
					r = (r >> 1) + b;
				end else begin
					r = r >> 1;
				end
				b = b >> 2;
			end
			return r;
		endfunction

		function longint unsigned log2_frac(longint unsigned m);
			int k;
			longint unsigned x, frac;
			k = 0;
			frac = 0;
			while (k < 63 && (m >> (k + 1)) != 0) k++;
			x = (k <= 31) ? (m << (31 - k)) : (m >> (k - 31));
			for (int i = 27; i >= 0; i--) begin
				x = (x * x) >> 31;
				if (x >= (64'd1 << 32)) begin
					frac = frac | (64'd1 << i);
					x = x >> 1;
				end
			end
			return (longint'(k) << 28) | frac;
		endfunction

		function longint taylor(longint unsigned x, bit want_sin);
			longint unsigned x2, term, d;
			longint sum;
			x2 = (x * x) >> 30;
			term = want_sin ? x : ONE_Q30;
			sum = term;
			for (int k = 1; k <= 7; k++) begin
				d = want_sin ? (2 * k) * (2 * k + 1) : (2 * k - 1) * (2 * k);
				term = ((term * x2) >> 30) / d;
				if (k % 2 == 1) sum = sum - longint'(term);
				else sum = sum + longint'(term);
			end
			if (sum < 0) sum = 0;
			if (sum > longint'(ONE_Q30)) sum = ONE_Q30;
			return sum;
		endfunction

		function logic signed [31:0] noisy_coord(logic signed [31:0] coord,
				logic [gna_pkg::UNIFORM_BITS-1:0] rc, logic [gna_pkg::UNIFORM_BITS-1:0] ac);
			longint unsigned t, r2, rad, p32, x;
			longint c, g, noise, sum;
			bit [1:0] quad;
			t = (longint'(gna_pkg::UNIFORM_BITS) << 28) - log2_frac(longint'(rc) + 1);
			r2 = (t * longint'(gna_pkg::LN2X2_Q30) + (64'd1 << 27)) >> 28;
			rad = int_sqrt(r2 << 26);
			p32 = (longint'(ac) << (32 - gna_pkg::UNIFORM_BITS)) & 64'hFFFF_FFFF;
			quad = p32[31:30];
			x = ((p32 & 64'h3FFF_FFFF) * longint'(gna_pkg::HALF_PI_Q30)) >> 30;
			case (quad)
				2'd0: c = taylor(x, 1'b0);
				2'd1: c = -taylor(x, 1'b1);
				2'd2: c = -taylor(x, 1'b0);
				default: c = taylor(x, 1'b1);
			endcase
			g = rshift_round(longint'(rad) * c, 34);
			noise = rshift_round(g * longint'(sigma), 24);
			sum = longint'(coord) + noise;
			if (sum > 64'sd2147483647) sum = 64'sd2147483647;
			if (sum < -64'sd2147483648) sum = -64'sd2147483648;
			return sum[31:0];
		endfunction

		function void note(point_t p);
			noisy_pt_t r;
			for (int i = 0; i < 3; i++)
				r.noisy[i] = noisy_coord(p.coord[i], p.rcode[i], p.acode[i]);
			pending.insert(pending.size(), r);
		endfunction

		function string check(noisy_pt_t got);
			noisy_pt_t want;
			string msg;
			msg = "";
			if (pending.size() == 0)
				return $sformatf("unexpected word x=%0d y=%0d z=%0d",
					got.noisy[0], got.noisy[1], got.noisy[2]);
			want = pending.pop_front();
			for (int i = 0; i < 3; i++)
				if (got.noisy[i] !== want.noisy[i])
					msg = {msg, $sformatf(" axis%0d got %0d want %0d", i,
						got.noisy[i], want.noisy[i])};
			return msg;
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_wr_en;
	logic [gna_pkg::SIGMA_W-1:0] cfg_wr_data;
	int mismatches;
	int accepted;
	int idle_cycles;
	bit drive_done;
	noise_scoreboard sb;

	gna_pt_if #(.UB(gna_pkg::UNIFORM_BITS)) pt_ch();
	gna_res_if res_ch();

	gaussian_noise_adder_core #(.UNIFORM_BITS(gna_pkg::UNIFORM_BITS)) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_pt(pt_ch),
		.out_pt(res_ch)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	task automatic report(input string msg);
		mismatches++;
		$display("mismatch at %0t:%s", $time, msg);
	endtask

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// input and output monitors
	always @(posedge clk) begin
		point_t p;
		noisy_pt_t r;
		string msg;
		if (arst_n && pt_ch.valid && pt_ch.ready) begin
			p.coord[0] = pt_ch.coord_x;
			p.coord[1] = pt_ch.coord_y;
			p.coord[2] = pt_ch.coord_z;
			p.rcode[0] = pt_ch.radius_code_x;
			p.rcode[1] = pt_ch.radius_code_y;
			p.rcode[2] = pt_ch.radius_code_z;
			p.acode[0] = pt_ch.angle_code_x;
			p.acode[1] = pt_ch.angle_code_y;
			p.acode[2] = pt_ch.angle_code_z;
			sb.note(p);
			accepted++;
			idle_cycles = 0;
		end
		if (arst_n && res_ch.valid && res_ch.ready) begin
			r.noisy[0] = res_ch.noisy_x;
			r.noisy[1] = res_ch.noisy_y;
			r.noisy[2] = res_ch.noisy_z;
			msg = sb.check(r);
			if (msg != "") report(msg);
			idle_cycles = 0;
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("tb_gaussian_noise_adder_core NOT OK");
				$finish;
			end
		end
	end

	// result side backpressure
	initial begin
		int n;
		res_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			res_ch.ready = 1'b1;
			repeat ($urandom_range(1, 30)) @(negedge clk);
			n = pick_gap();
			if (n > 0) begin
				res_ch.ready = 1'b0;
				repeat (n) @(negedge clk);
			end
		end
	end

	task automatic send_point(input point_t p);
		int seen;
		int g;
		pt_ch.coord_x = p.coord[0];
		pt_ch.coord_y = p.coord[1];
		pt_ch.coord_z = p.coord[2];
		pt_ch.radius_code_x = p.rcode[0];
		pt_ch.radius_code_y = p.rcode[1];
		pt_ch.radius_code_z = p.rcode[2];
		pt_ch.angle_code_x = p.acode[0];
		pt_ch.angle_code_y = p.acode[1];
		pt_ch.angle_code_z = p.acode[2];
		pt_ch.valid = 1'b1;
		seen = accepted;
		while (accepted == seen) @(negedge clk);
		g = pick_gap();
		if (g > 0) begin
			pt_ch.valid = 1'b0;
			repeat (g) @(negedge clk);
		end
	endtask

	task automatic wait_drained();
		pt_ch.valid = 1'b0;
		while (sb.pending.size() != 0) @(negedge clk);
	endtask

	task automatic write_sigma(input logic [gna_pkg::SIGMA_W-1:0] v);
		wait_drained();
		repeat (gna_pkg::lane_lat(gna_pkg::UNIFORM_BITS) + 4) @(negedge clk);
		cfg_wr_en = 1'b1;
		cfg_wr_data = v;
		@(negedge clk);
		cfg_wr_en = 1'b0;
		sb.sigma = v;
	endtask

	function automatic point_t rand_point();
		point_t p;
		int sel;
		for (int i = 0; i < 3; i++) begin
			sel = $urandom_range(0, 9);
			if (sel < 4) p.coord[i] = $urandom;
			else if (sel < 7) p.coord[i] = $signed($urandom_range(0, 32'h0020_0000))
				- 32'sh0010_0000;
			else if (sel < 8) p.coord[i] = 32'sh7FFF_FFFF - $urandom_range(0, 32'h0100_0000);
			else p.coord[i] = 32'sh8000_0000 + $urandom_range(0, 32'h0100_0000);
			sel = $urandom_range(0, 9);
			if (sel == 0) p.rcode[i] = '1;
			else if (sel == 1) p.rcode[i] = $urandom_range(0, 15);
			else p.rcode[i] = $urandom;
			p.acode[i] = $urandom;
		end
		return p;
	endfunction

	function automatic point_t same_point(logic signed [31:0] c,
			logic [gna_pkg::UNIFORM_BITS-1:0] rc, logic [gna_pkg::UNIFORM_BITS-1:0] ac);
		point_t p;
		for (int i = 0; i < 3; i++) begin
			p.coord[i] = c;
			p.rcode[i] = rc;
			p.acode[i] = ac;
		end
		return p;
	endfunction

	task automatic directed_set();
		logic [gna_pkg::UNIFORM_BITS-1:0] ang [6];
		ang = '{16'h0000, 16'h4000, 16'h8000, 16'hC000, 16'hFFFF, 16'h2AAA};
		// top radius code: no noise
		send_point(same_point(32'sh1234_5678, '1, 16'h1357));
		// smallest u, every quadrant boundary and two angles between
		foreach (ang[i]) send_point(same_point(32'sh0000_0000, '0, ang[i]));
		// saturation at both ends
		send_point(same_point(32'sh7FFF_FFFF, '0, 16'h0000));
		send_point(same_point(32'sh8000_0000, '0, 16'h8000));
		send_point(same_point(32'sh7FFF_FFFF, '1, 16'hFFFF));
		send_point(same_point(32'sh8000_0000, '1, 16'h0000));
		send_point(same_point(32'sh7FFF_0000, 16'h0001, 16'h0001));
		send_point(same_point(-32'sh7FFF_0000, 16'h8000, 16'h7FFF));
	endtask

	task automatic random_phase(input int n);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 59) == 0) wait_drained();
			send_point(rand_point());
		end
	endtask

	initial begin
		sb = new();
		mismatches = 0;
		accepted = 0;
		idle_cycles = 0;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		pt_ch.valid = 1'b0;
		pt_ch.coord_x = '0;
		pt_ch.coord_y = '0;
		pt_ch.coord_z = '0;
		pt_ch.radius_code_x = '0;
		pt_ch.radius_code_y = '0;
		pt_ch.radius_code_z = '0;
		pt_ch.angle_code_x = '0;
		pt_ch.angle_code_y = '0;
		pt_ch.angle_code_z = '0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset sigma
		directed_set();
		random_phase(100);
		wait_drained();

		write_sigma('1);
		directed_set();
		random_phase(80);

		write_sigma('0);
		directed_set();
		random_phase(40);

		write_sigma(24'd1);
		random_phase(60);

		write_sigma($urandom_range(24'h00_0100, 24'h0F_FFFF));
		random_phase(120);

		write_sigma(gna_pkg::SIGMA_RESET);
		random_phase(100);

		wait_drained();
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (mismatches == 0 && sb.pending.size() == 0) begin
			$display("tb_gaussian_noise_adder_core OK");
		end else begin
			$display("tb_gaussian_noise_adder_core NOT OK");
		end
		$finish;
	end

endmodule
